// ----- sv/short_message_hash32_defines.svh -----
// ---------------------------------------------------------------------------
// short_message_hash32_defines.svh
// Assertion macros used by the short message hash pipeline control.
// ---------------------------------------------------------------------------
`ifndef SHORT_MESSAGE_HASH32_DEFINES_SVH
`define SHORT_MESSAGE_HASH32_DEFINES_SVH

`ifndef SYNTHESIS

// Condition that must hold at every rising clock edge outside reset.
`define SHM_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition in one cycle that implies another in the next cycle.
`define SHM_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define SHM_ASSERT_HOLDS(lbl, cond, msg)
`define SHM_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

// ----- sv/shm32_pkg.sv -----
// ---------------------------------------------------------------------------
// shm32_pkg
// Constants, types and mixing functions of the short message hash.
// ---------------------------------------------------------------------------
`default_nettype none

package shm32_pkg;

    // Register stages from the input registers to the output register.
    localparam int NumStages = 9;

    localparam logic [31:0] MixC1  = 32'hcc9e2d51;
    localparam logic [31:0] MixC2  = 32'h1b873593;
    localparam logic [31:0] FinC1  = 32'h85ebca6b;
    localparam logic [31:0] FinC2  = 32'hc2b2ae35;
    localparam logic [31:0] MixAdd = 32'he6546b64;
    localparam logic [31:0] SeedC  = 32'd9;

    localparam logic [3:0] LenMin = 4'd5;
    localparam logic [3:0] LenMax = 4'd12;
    localparam logic [3:0] LenHalfSplit = 4'd8;

    typedef logic [NumStages-1:0] stage_vec_t;

    typedef struct packed {
        stage_vec_t en;
        stage_vec_t vld;
    } pipe_ctrl_t;

    function automatic logic [31:0] rotr17(input logic [31:0] v);
        return {v[16:0], v[31:17]};
    endfunction

    function automatic logic [31:0] rotr19(input logic [31:0] v);
        return {v[18:0], v[31:19]};
    endfunction

    // One Murmur3 combining step after the key has been premixed.
    function automatic logic [31:0] mix_round(input logic [31:0] h, input logic [31:0] k);
        logic [31:0] t;
        t = rotr19(h ^ k);
        return t + {t[29:0], 2'b00} + MixAdd;
    endfunction

endpackage

`default_nettype wire

// ----- sv/shm32_ctrl.sv -----
// ---------------------------------------------------------------------------
// shm32_ctrl
// Valid bits and per-stage load enables of the hash pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
`include "short_message_hash32_defines.svh"

module shm32_ctrl
    import shm32_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic out_stall,
    output pipe_ctrl_t ctrl
);

    stage_vec_t vld_reg;
    stage_vec_t vld_next;
    stage_vec_t en;

    // A stage loads when it is empty or when the stage after it loads,
    // so bubbles close up while the output is stalled.
    always_comb
    begin
        en[NumStages-1] = !vld_reg[NumStages-1] || !out_stall;
        for (int k = NumStages - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (en[0])
        begin
            vld_next[0] = in_valid;
        end
        for (int k = 1; k < NumStages; k++)
        begin
            if (en[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign ctrl.en  = en;
    assign ctrl.vld = vld_reg;

    `SHM_ASSERT_HOLDS(a_stall_only_full, en[0] || (&vld_reg), "input stalled with a bubble in the pipe")
    `SHM_ASSERT_NEXT(a_accept_lands, in_valid && en[0], vld_reg[0], "accepted beat not in first stage")
    `SHM_ASSERT_NEXT(a_last_held, vld_reg[NumStages-1] && out_stall, vld_reg[NumStages-1], "stalled result dropped")
    `SHM_ASSERT_NEXT(a_advance_lands, vld_reg[NumStages-2] && en[NumStages-1], vld_reg[NumStages-1], "beat lost entering output stage")

endmodule

`default_nettype wire

// ----- sv/short_message_hash32.sv -----
// ---------------------------------------------------------------------------
// short_message_hash32
// 32-bit hash of a 5 to 12 byte message (CityHash32 short-length path).
// ---------------------------------------------------------------------------
//   Channel  Handshake                Payload
//   msg      msg_valid / msg_stall    bytes_0_to_3, bytes_4_to_7, bytes_8_to_11, length
//   hash     hash_valid / hash_stall  hash_value
//
// One beat is accepted per cycle while msg_stall is low; each result passes
// through the nine register stages of the mixing chain, s1 to s9, before it leaves.
// Reset clears only the valid bits; the data registers are not reset.
// A stall on the hash channel holds the output register; earlier stages keep
// filling empty slots, and msg_stall rises only when every stage is occupied.
// ---------------------------------------------------------------------------
`default_nettype none

module short_message_hash32
    import shm32_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        msg_valid,
    output logic             msg_stall,
    input  wire logic [31:0] bytes_0_to_3,
    input  wire logic [31:0] bytes_4_to_7,
    input  wire logic [31:0] bytes_8_to_11,
    input  wire logic [3:0]  length,
    output logic             hash_valid,
    input  wire logic        hash_stall,
    output logic [31:0]      hash_value
);

    pipe_ctrl_t ctrl;

    logic [3:0]  len_sat;
    logic [3:0]  tail_off;
    logic [95:0] msg_bits;
    logic [31:0] msg_shifted;
    logic [5:0]  len_x5;
    logic [31:0] a_next;
    logic [31:0] b_next;
    logic [31:0] c_next;

    // Stage 1: seeded loads.
    logic [31:0] s1_a_reg, s1_b_reg, s1_c_reg, s1_d_reg;
    // Stage 2: keys times the first mixing constant.
    logic [31:0] s2_a_reg, s2_b_reg, s2_c_reg, s2_d_reg;
    // Stage 3: fully premixed keys.
    logic [31:0] s3_a_reg, s3_b_reg, s3_c_reg, s3_d_reg;
    // Stages 4 to 6: the chained combining rounds.
    logic [31:0] s4_h_reg, s4_b_reg, s4_c_reg;
    logic [31:0] s5_h_reg, s5_c_reg;
    logic [31:0] s6_h_reg;
    // Stages 7 to 9: final avalanche.
    logic [31:0] s7_m_reg;
    logic [31:0] s8_m_reg;
    logic [31:0] s9_hash_reg;

    logic [31:0] s7_pre;
    logic [31:0] s8_pre;

    shm32_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (msg_valid),
        .out_stall (hash_stall),
        .ctrl      (ctrl)
    );

    assign msg_stall  = !ctrl.en[0];
    assign hash_valid = ctrl.vld[NumStages-1];
    assign hash_value = s9_hash_reg;

    always_comb
    begin
        if (length < LenMin)
        begin
            len_sat = LenMin;
        end
        else if (length > LenMax)
        begin
            len_sat = LenMax;
        end
        else
        begin
            len_sat = length;
        end
    end

    // The tail load starts at byte length-4, which is always 1 to 8.
    assign tail_off    = len_sat - 4'd4;
    assign msg_bits    = {bytes_8_to_11, bytes_4_to_7, bytes_0_to_3};
    assign msg_shifted = msg_bits[{tail_off, 3'b000} +: 32];
    assign len_x5      = {len_sat, 2'b00} + {2'b00, len_sat};

    assign a_next = bytes_0_to_3 + {28'd0, len_sat};
    assign b_next = msg_shifted + {26'd0, len_x5};
    assign c_next = ((len_sat >= LenHalfSplit) ? bytes_4_to_7 : bytes_0_to_3) + SeedC;

    assign s7_pre = s6_h_reg ^ {16'd0, s6_h_reg[31:16]};
    assign s8_pre = s7_m_reg ^ {13'd0, s7_m_reg[31:13]};

    always_ff @(posedge clk)
    begin
        if (ctrl.en[0])
        begin
            s1_a_reg <= a_next;
            s1_b_reg <= b_next;
            s1_c_reg <= c_next;
            s1_d_reg <= {26'd0, len_x5};
        end
        if (ctrl.en[1])
        begin
            s2_a_reg <= s1_a_reg * MixC1;
            s2_b_reg <= s1_b_reg * MixC1;
            s2_c_reg <= s1_c_reg * MixC1;
            s2_d_reg <= s1_d_reg;
        end
        if (ctrl.en[2])
        begin
            s3_a_reg <= rotr17(s2_a_reg) * MixC2;
            s3_b_reg <= rotr17(s2_b_reg) * MixC2;
            s3_c_reg <= rotr17(s2_c_reg) * MixC2;
            s3_d_reg <= s2_d_reg;
        end
        if (ctrl.en[3])
        begin
            s4_h_reg <= mix_round(s3_d_reg, s3_a_reg);
            s4_b_reg <= s3_b_reg;
            s4_c_reg <= s3_c_reg;
        end
        if (ctrl.en[4])
        begin
            s5_h_reg <= mix_round(s4_h_reg, s4_b_reg);
            s5_c_reg <= s4_c_reg;
        end
        if (ctrl.en[5])
        begin
            s6_h_reg <= mix_round(s5_h_reg, s5_c_reg);
        end
        if (ctrl.en[6])
        begin
            s7_m_reg <= s7_pre * FinC1;
        end
        if (ctrl.en[7])
        begin
            s8_m_reg <= s8_pre * FinC2;
        end
        if (ctrl.en[8])
        begin
            s9_hash_reg <= s8_m_reg ^ {16'd0, s8_m_reg[31:16]};
        end
    end

endmodule

`default_nettype wire
